>>> rtl/core/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Types and constants shared by the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int unsigned CountW     = 25;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BppW       = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam logic [ByteW-1:0] RunFlag    = 8'd128;
  localparam logic [BppW-1:0]  ColorBytes = 3'd3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RLE_MODE    = 2'd0,
    REG_PIXEL_BYTES = 2'd1,
    REG_PIXEL_COUNT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              rle_mode;
    logic [BppW-1:0]   pixel_bytes;
    logic [CountW-1:0] pixel_count;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] repeat_count;
    logic             image_done;
  } pixel_t;

endpackage

>>> rtl/core/trd_in_stage.sv
// ----------------------------------------------------------------------------
// trd_in_stage
// Input register holding one data byte ahead of the decode step.
// ----------------------------------------------------------------------------
module trd_in_stage import trd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      byte_d  = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> rtl/core/trd_decode.sv
// ----------------------------------------------------------------------------
// trd_decode
// Packet and byte-phase tracking; builds one pixel word per finished pixel.
// ----------------------------------------------------------------------------
module trd_decode import trd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output pixel_t           res_o
);

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2,
    PH_ALPHA = 2'd3
  } phase_e;

  logic [CountW-1:0] pixels_done_q, pixels_done_d;
  logic [ByteW-1:0]  left_q, left_d;
  logic              is_run_q, is_run_d;
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  blue_q, blue_d, green_q, green_d, red_q, red_d;

  logic              has_alpha, header, complete, run_pix, done;
  logic [CountW-1:0] total, remaining, done_sum;
  logic [ByteW-1:0]  want, rep;

  assign has_alpha = cfg_i.pixel_bytes > ColorBytes;
  assign header    = cfg_i.rle_mode && (left_q == '0);
  assign complete  = (phase_q == PH_ALPHA) || ((phase_q == PH_RED) && !has_alpha);
  assign run_pix   = cfg_i.rle_mode && is_run_q;
  assign want      = run_pix ? left_q : ByteW'(1);
  assign total     = (cfg_i.pixel_count == '0) ? CountW'(1) : cfg_i.pixel_count;
  assign remaining = (pixels_done_q < total) ? (total - pixels_done_q) : CountW'(1);
  assign done      = CountW'(want) >= remaining;
  assign rep       = done ? remaining[ByteW-1:0] : want;
  assign done_sum  = pixels_done_q + CountW'(want);

  always_comb begin
    pixels_done_d = pixels_done_q;
    left_d        = left_q;
    is_run_d      = is_run_q;
    phase_d       = phase_q;
    blue_d        = blue_q;
    green_d       = green_q;
    red_d         = red_q;
    res_valid_o   = 1'b0;
    if (step_i) begin
      if (header) begin
        is_run_d = byte_i >= RunFlag;
        left_d   = (byte_i & (RunFlag - ByteW'(1))) + ByteW'(1);
        phase_d  = PH_BLUE;
      end else begin
        case (phase_q)
          PH_BLUE:  blue_d  = byte_i;
          PH_GREEN: green_d = byte_i;
          PH_RED:   red_d   = byte_i;
          default: ;
        endcase
        if (!complete) begin
          phase_d = phase_e'(phase_q + 2'd1);
        end else begin
          res_valid_o = 1'b1;
          phase_d     = PH_BLUE;
          if (run_pix) begin
            left_d = '0;
          end else if (cfg_i.rle_mode) begin
            left_d = left_q - ByteW'(1);
          end
          pixels_done_d = done_sum;
          if (done) begin
            pixels_done_d = '0;
            left_d        = '0;
            is_run_d      = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    res_o.red          = red_d;
    res_o.green        = green_d;
    res_o.blue         = blue_d;
    res_o.repeat_count = rep;
    res_o.image_done   = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_done_q <= '0;
      left_q        <= '0;
      is_run_q      <= 1'b0;
      phase_q       <= PH_BLUE;
      blue_q        <= '0;
      green_q       <= '0;
      red_q         <= '0;
    end else begin
      pixels_done_q <= pixels_done_d;
      left_q        <= left_d;
      is_run_q      <= is_run_d;
      phase_q       <= phase_d;
      blue_q        <= blue_d;
      green_q       <= green_d;
      red_q         <= red_d;
    end
  end

endmodule

>>> rtl/core/trd_out_stage.sv
// ----------------------------------------------------------------------------
// trd_out_stage
// Result register holding one pixel word until the consumer takes it.
// ----------------------------------------------------------------------------
module trd_out_stage import trd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  logic   res_valid_i,
  input  pixel_t res_i,
  input  logic   out_ready_i,
  output logic   out_valid_o,
  output pixel_t res_o
);

  logic   valid_q, valid_d;
  pixel_t res_q, res_d;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (load_i) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/core/tga_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// TGA image data decoder: bytes in, RGB pixels with repeat counts out.
// ----------------------------------------------------------------------------
// Takes one image data byte per cycle while the consumer keeps up. A byte
// sits in the input register, is decoded against the packet and phase
// state, and a finished pixel lands in the result register. Throughput is
// one byte per cycle while the consumer keeps up; a stalled result word
// halts the decode step and the input register behind it. Configuration
// writes are registered; the user must make them only while the block is
// idle, which the block itself does not enforce.
module tga_rle_pixel_decoder_core import trd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CountW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ByteW-1:0]   data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   red_o,
  output logic [ByteW-1:0]   green_o,
  output logic [ByteW-1:0]   blue_o,
  output logic [ByteW-1:0]   repeat_count_o,
  output logic               image_done_o
);

  cfg_t             cfg_q, cfg_d;
  logic             byte_valid, advance, res_valid;
  logic [ByteW-1:0] byte_w;
  pixel_t           res_w, out_w;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RLE_MODE:    cfg_d.rle_mode    = cfg_data_i[0];
        REG_PIXEL_BYTES: cfg_d.pixel_bytes = cfg_data_i[BppW-1:0];
        REG_PIXEL_COUNT: cfg_d.pixel_count = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rle_mode    <= 1'b0;
      cfg_q.pixel_bytes <= ColorBytes;
      cfg_q.pixel_count <= CountW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign advance = byte_valid && (!out_valid_o || out_ready_i);

  trd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .valid_o     (byte_valid),
    .byte_o      (byte_w)
  );

  trd_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (byte_w),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res_w)
  );

  trd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_valid_i (res_valid),
    .res_i       (res_w),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .res_o       (out_w)
  );

  assign red_o          = out_w.red;
  assign green_o        = out_w.green;
  assign blue_o         = out_w.blue;
  assign repeat_count_o = out_w.repeat_count;
  assign image_done_o   = out_w.image_done;

endmodule

>>> test/tga_rle_pixel_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_core_tb
// Self-checking bench for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
// Bytes and register writes are queued up front: a short directed stream
// for the corner cases, then random phases of mostly well-formed packets.
// A clocked driver feeds the byte and register channels and decodes every
// accepted byte in a local predictor. A clocked monitor compares every
// pixel word with the oldest predicted one. Both sides idle at random,
// except in periodic calm windows.
module tga_rle_pixel_decoder_core_tb;
  import trd_pkg::*;

  localparam int IdlePct     = 20;
  localparam int CalmPeriod  = 3000;
  localparam int CalmFrom    = 2400;
  localparam int QuietCycles = 6;
  localparam int DrainCycles = 20;
  localparam int RandomBytes = 1800;
  localparam int CycleLimit  = 200000;

  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  localparam logic [1:0] PhaseBlue  = 2'd0;
  localparam logic [1:0] PhaseGreen = 2'd1;
  localparam logic [1:0] PhaseRed   = 2'd2;
  localparam logic [1:0] PhaseAlpha = 2'd3;

  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [CountW-1:0]  value;
  } stream_word_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CountW-1:0]  cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [ByteW-1:0]   data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ByteW-1:0]   red, green, blue, repeat_count;
  logic               image_done;

  stream_word_t stream_q[$];
  pixel_t       pending_pixels[$];

  // decoder state mirror
  logic              dec_rle    = 1'b0;
  logic [BppW-1:0]   dec_bpp    = 3'd3;
  logic [CountW-1:0] dec_pixels = 25'd1;
  logic [CountW-1:0] dec_done   = '0;
  logic [ByteW-1:0]  dec_left   = '0;
  logic              dec_run    = 1'b0;
  logic [1:0]        dec_phase  = PhaseBlue;
  logic [ByteW-1:0]  dec_red    = '0;
  logic [ByteW-1:0]  dec_green  = '0;
  logic [ByteW-1:0]  dec_blue   = '0;

  int   cycle_cnt    = 0;
  int   quiet        = 0;
  int   errors       = 0;
  int   bytes_taken  = 0;
  int   writes_done  = 0;
  int   pixels_seen  = 0;
  int   images_seen  = 0;
  int   gen_bytes    = 0;
  logic gen_rle      = 1'b0;
  logic gen_alpha    = 1'b0;
  logic calm;

  logic         in_busy, cfg_busy;
  stream_word_t head;

  assign calm = (cycle_cnt % CalmPeriod) >= CalmFrom;

  tga_rle_pixel_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .data_byte_i   (data_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .red_o         (red),
    .green_o       (green),
    .blue_o        (blue),
    .repeat_count_o(repeat_count),
    .image_done_o  (image_done)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("tga_rle_pixel_decoder_core verification failed");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] d);
    case (idx)
      REG_RLE_MODE:    dec_rle    = d[0];
      REG_PIXEL_BYTES: dec_bpp    = d[BppW-1:0];
      REG_PIXEL_COUNT: dec_pixels = d;
      default: ;
    endcase
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic              has_alpha;
    logic [ByteW-1:0]  want;
    logic [CountW-1:0] total, remain, rep;
    pixel_t            px;
    has_alpha = dec_bpp > ColorBytes;
    if (dec_rle && dec_left == '0) begin
      dec_run   = (b >= RunFlag);
      dec_left  = ByteW'(b[ByteW-2:0]) + 8'd1;
      dec_phase = PhaseBlue;
      return;
    end
    case (dec_phase)
      PhaseBlue:  dec_blue  = b;
      PhaseGreen: dec_green = b;
      PhaseRed:   dec_red   = b;
      default: ;
    endcase
    if (!(dec_phase == PhaseAlpha || (dec_phase == PhaseRed && !has_alpha))) begin
      dec_phase = dec_phase + 2'd1;
      return;
    end
    dec_phase = PhaseBlue;
    if (dec_rle && dec_run) begin
      want     = dec_left;
      dec_left = '0;
    end else begin
      want = 8'd1;
      if (dec_rle) dec_left = dec_left - 8'd1;
    end
    total  = (dec_pixels == '0) ? CountW'(1) : dec_pixels;
    remain = (dec_done < total) ? total - dec_done : CountW'(1);
    rep    = (CountW'(want) < remain) ? CountW'(want) : remain;
    dec_done = dec_done + rep;
    px.image_done = (rep >= remain);
    if (px.image_done) begin
      dec_done  = '0;
      dec_left  = '0;
      dec_run   = 1'b0;
      dec_phase = PhaseBlue;
    end
    px.red          = dec_red;
    px.green        = dec_green;
    px.blue         = dec_blue;
    px.repeat_count = rep[ByteW-1:0];
    pending_pixels.push_back(px);
  endtask

  task automatic compare_field(input string name, input logic [ByteW-1:0] got,
                               input logic [ByteW-1:0] exp);
    if (got != exp) report_error($sformatf("%s: got %0d, expected %0d", name, got, exp));
  endtask

  task automatic check_pixel();
    pixel_t exp;
    if (pending_pixels.size() == 0) begin
      report_error($sformatf("unexpected pixel word r=%0d g=%0d b=%0d rep=%0d done=%0d",
                             red, green, blue, repeat_count, image_done));
      return;
    end
    exp = pending_pixels.pop_front();
    pixels_seen++;
    if (image_done) images_seen++;
    compare_field("red", red, exp.red);
    compare_field("green", green, exp.green);
    compare_field("blue", blue, exp.blue);
    compare_field("repeat_count", repeat_count, exp.repeat_count);
    compare_field("image_done", ByteW'(image_done), ByteW'(exp.image_done));
  endtask

  task automatic push_byte(input logic [ByteW-1:0] b);
    stream_q.push_back('{is_cfg: 1'b0, idx: '0, value: CountW'(b)});
    gen_bytes++;
  endtask

  task automatic push_cfg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] d);
    stream_q.push_back('{is_cfg: 1'b1, idx: idx, value: d});
  endtask

  task automatic push_pixel();
    repeat (gen_alpha ? 4 : 3) push_byte(ByteW'($urandom_range(0, 255)));
  endtask

  // byte and register channels; predictor runs on every accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      data_byte <= '0;
      cfg_valid <= 1'b0;
      cfg_index <= '0;
      cfg_data  <= '0;
    end else begin
      in_busy  = in_valid;
      cfg_busy = cfg_valid;
      if (in_valid && in_ready) begin
        decode_byte(data_byte);
        bytes_taken++;
        in_busy = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_reg(cfg_index, cfg_data);
        writes_done++;
        cfg_busy = 1'b0;
      end
      if (in_busy || cfg_busy || pending_pixels.size() != 0) quiet = 0;
      else if (quiet < QuietCycles) quiet++;
      if (!in_busy && !cfg_busy && stream_q.size() != 0) begin
        if (stream_q[0].is_cfg) begin
          if (quiet >= QuietCycles) begin
            head = stream_q.pop_front();
            cfg_index <= head.idx;
            cfg_data  <= head.value;
            cfg_busy  = 1'b1;
          end
        end else if (calm || $urandom_range(0, 99) >= IdlePct) begin
          head = stream_q.pop_front();
          data_byte <= head.value[ByteW-1:0];
          in_busy   = 1'b1;
        end
      end
      in_valid  <= in_busy;
      cfg_valid <= cfg_busy;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_pixel();
      out_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  initial begin
    int                random_start, phase_start, phase_len, pick, len;
    logic [CountW-1:0] noise, count_val;
    logic [BppW-1:0]   bpp_val;

    // zero image size acts as one pixel; byte extremes
    push_cfg(REG_PIXEL_COUNT, '0);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h55);
    // longest run clipped at the end of a two pixel image, alpha present
    push_cfg(REG_RLE_MODE, 25'd1);
    push_cfg(REG_PIXEL_BYTES, 25'd7);
    push_cfg(REG_PIXEL_COUNT, 25'd2);
    push_cfg(RegSpare, '1);
    push_byte(8'hFF);
    push_byte(8'h12); push_byte(8'h34); push_byte(8'h56); push_byte(8'h78);
    // alpha switched off while the alpha byte is due
    push_cfg(REG_PIXEL_COUNT, 25'd100);
    push_byte(8'h80);
    push_byte(8'hA1); push_byte(8'hB2); push_byte(8'hC3);
    push_cfg(REG_PIXEL_BYTES, 25'd3);
    push_byte(8'h99);
    // raw packet interrupted by an uncompressed pixel, then size lowered
    push_byte(8'h02);
    push_byte(8'h01); push_byte(8'h02); push_byte(8'h04);
    push_cfg(REG_RLE_MODE, '0);
    push_byte(8'h08); push_byte(8'h10); push_byte(8'h20);
    push_cfg(REG_RLE_MODE, 25'd1);
    push_cfg(REG_PIXEL_COUNT, 25'd2);
    push_byte(8'h40); push_byte(8'h80); push_byte(8'hFE);
    gen_rle   = 1'b1;
    gen_alpha = 1'b0;

    random_start = gen_bytes;
    while (gen_bytes - random_start < RandomBytes) begin
      noise = CountW'($urandom);
      if ($urandom_range(0, 99) < 50) begin
        gen_rle = ($urandom_range(0, 99) < 75);
        push_cfg(REG_RLE_MODE,
                 $urandom_range(0, 1) ? {noise[CountW-1:1], gen_rle} : CountW'(gen_rle));
      end
      if ($urandom_range(0, 99) < 40) begin
        bpp_val = ($urandom_range(0, 99) < 15) ? BppW'($urandom_range(0, 7)) :
                  ($urandom_range(0, 1) ? 3'd3 : 3'd4);
        gen_alpha = bpp_val > ColorBytes;
        push_cfg(REG_PIXEL_BYTES,
                 $urandom_range(0, 1) ? {noise[CountW-1:BppW], bpp_val} : CountW'(bpp_val));
      end
      if ($urandom_range(0, 99) < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)       count_val = 25'd16777216;
        else if (pick < 7)  count_val = '1;
        else if (pick < 10) count_val = noise;
        else if (pick < 14) count_val = '0;
        else                count_val = CountW'($urandom_range(1, 40));
        push_cfg(REG_PIXEL_COUNT, count_val);
      end
      if ($urandom_range(0, 99) < 4) push_cfg(RegSpare, noise);

      phase_start = gen_bytes;
      phase_len   = $urandom_range(30, 150);
      while (gen_bytes - phase_start < phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          push_byte(ByteW'($urandom_range(0, 255)));
        end else if (!gen_rle) begin
          push_pixel();
        end else if (pick < 54) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
          push_byte(RunFlag + ByteW'(len));
          push_pixel();
        end else begin
          len = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 5);
          push_byte(ByteW'(len));
          repeat (len + 1) push_pixel();
        end
      end
    end

    while (stream_q.size() != 0 || in_valid || cfg_valid || pending_pixels.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d data bytes and %0d register writes over %0d cycles",
             bytes_taken, writes_done, cycle_cnt);
    $display("Checked %0d pixel words, %0d of them closing an image", pixels_seen, images_seen);
    if (errors == 0) begin
      $display("tga_rle_pixel_decoder_core verification clean");
    end else begin
      $display("tga_rle_pixel_decoder_core verification failed");
    end
    $finish;
  end

endmodule
